// File: hw/rtl/nqslp_pkg.sv
`timescale 1ns / 1ps

package nqslp_pkg;

	localparam int MAX_ENTRIES    = 256;
	localparam int MAX_TEXT_BYTES = 64;
	localparam int TEXT_CAP       = MAX_TEXT_BYTES - 1;

	localparam int TEXT_LEN_W  = $clog2(TEXT_CAP + 1);
	localparam int TEXT_ADDR_W = (TEXT_CAP > 1) ? $clog2(TEXT_CAP) : 1;
	localparam int ENTRY_CNT_W = ($clog2(MAX_ENTRIES + 1) > 8) ? $clog2(MAX_ENTRIES + 1) : 8;

	localparam int INDEX_W = 8;
	localparam int ID_W    = 31;
	localparam int BYTE_W  = 8;

	localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

	localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;
	localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

	typedef struct packed {
		logic id_load;
		logic id_mac;
		logic len_clear;
		logic buf_write;
		logic entry_take;
		logic count_clear;
		logic rd_start;
		logic rd_next;
		logic out_load;
		logic out_empty;
	} nqslp_cmd_t;

	typedef struct packed {
		logic is_space;
		logic is_digit;
		logic is_quote;
		logic is_lf;
		logic table_full;
		logic len_full;
		logic len_zero;
		logic rd_last;
		logic out_free;
	} nqslp_sts_t;

endpackage

// File: hw/rtl/numbered_quoted_string_line_parser_unit.sv
`timescale 1ns / 1ps

// Parses a text buffer one byte item per cycle into numbered entries of the form
// <id> ... "<text>", skipping blank lines, comment lines and lines without a leading
// digit. While scanning, a byte item is taken every cycle. At a closing quote the
// input stalls while the buffered text is read back from the text RAM: the read is
// started first, then each text byte is read and loaded into the output register in
// turn, and an output stall holds the input longer. Each text byte leaves as one
// result item, and an empty entry as a single item marked empty; the output register
// lets the scan resume while the last result of an entry still waits to be taken.

module numbered_quoted_string_line_parser_unit
	import nqslp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  logic [BYTE_W-1:0]  data_byte,
	input  logic               end_of_data,
	output logic               entry_valid,
	input  logic               entry_stall,
	output logic [INDEX_W-1:0] entry_index,
	output logic [ID_W-1:0]    entry_id,
	output logic [BYTE_W-1:0]  text_byte,
	output logic               text_empty,
	output logic               last_of_entry
);

	nqslp_cmd_t cmd;
	nqslp_sts_t sts;

	nqslp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.end_of_data(end_of_data),
		.sts        (sts),
		.cmd        (cmd),
		.byte_stall (byte_stall)
	);

	nqslp_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (data_byte),
		.cmd          (cmd),
		.sts          (sts),
		.entry_valid  (entry_valid),
		.entry_stall  (entry_stall),
		.entry_index  (entry_index),
		.entry_id     (entry_id),
		.text_byte    (text_byte),
		.text_empty   (text_empty),
		.last_of_entry(last_of_entry)
	);

endmodule

// File: hw/rtl/nqslp_ram.sv
`timescale 1ns / 1ps

module nqslp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hw/rtl/nqslp_dp.sv
`timescale 1ns / 1ps

module nqslp_dp
	import nqslp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [BYTE_W-1:0]  data_byte,
	input  nqslp_cmd_t         cmd,
	output nqslp_sts_t         sts,
	output logic               entry_valid,
	input  logic               entry_stall,
	output logic [INDEX_W-1:0] entry_index,
	output logic [ID_W-1:0]    entry_id,
	output logic [BYTE_W-1:0]  text_byte,
	output logic               text_empty,
	output logic               last_of_entry
);

	logic [ID_W-1:0]        id_q;
	logic [TEXT_LEN_W-1:0]  len_q;
	logic [ENTRY_CNT_W-1:0] count_q;
	logic [INDEX_W-1:0]     snap_idx_q;
	logic [ID_W-1:0]        snap_id_q;
	logic [TEXT_LEN_W-1:0]  snap_len_q;
	logic [TEXT_ADDR_W-1:0] rd_addr_q;
	logic                   out_valid_q;
	logic [INDEX_W-1:0]     out_idx_q;
	logic [ID_W-1:0]        out_id_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   out_empty_q;
	logic                   out_last_q;

	logic [3:0]             digit_val;
	logic [ID_W+3:0]        id_prod;
	logic [ID_W-1:0]        id_next;
	logic [TEXT_ADDR_W-1:0] rd_addr;
	logic [BYTE_W-1:0]      rd_data;

	assign digit_val = 4'(data_byte - CHAR_ZERO);
	assign id_prod = ((ID_W + 4)'(id_q) << 3) + ((ID_W + 4)'(id_q) << 1)
		+ (ID_W + 4)'(digit_val);
	assign id_next = (id_prod > (ID_W + 4)'(ID_MAX)) ? ID_MAX : id_prod[ID_W-1:0];

	assign sts.is_space   = (data_byte == CHAR_SPACE)
		|| ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));
	assign sts.is_digit   = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
	assign sts.is_quote   = (data_byte == CHAR_QUOTE);
	assign sts.is_lf      = (data_byte == CHAR_LF);
	assign sts.table_full = (count_q >= ENTRY_CNT_W'(MAX_ENTRIES));
	assign sts.len_full   = (len_q == TEXT_LEN_W'(TEXT_CAP));
	assign sts.len_zero   = (snap_len_q == '0);
	assign sts.rd_last    = ((TEXT_LEN_W'(rd_addr_q) + TEXT_LEN_W'(1)) == snap_len_q);
	assign sts.out_free   = !out_valid_q || !entry_stall;

	assign rd_addr = cmd.rd_start ? '0 : rd_addr_q + TEXT_ADDR_W'(1);

	nqslp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(TEXT_CAP)
	) u_text_ram (
		.clk  (clk),
		.we   (cmd.buf_write),
		.waddr(len_q[TEXT_ADDR_W-1:0]),
		.wdata(data_byte),
		.re   (cmd.rd_start | cmd.rd_next),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q        <= '0;
			len_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.id_load) begin
				id_q <= ID_W'(digit_val);
			end else if (cmd.id_mac) begin
				id_q <= id_next;
			end
			if (cmd.len_clear) begin
				len_q <= '0;
			end else if (cmd.buf_write) begin
				len_q <= len_q + TEXT_LEN_W'(1);
			end
			if (cmd.count_clear) begin
				count_q <= '0;
			end else if (cmd.entry_take) begin
				count_q <= count_q + ENTRY_CNT_W'(1);
			end
			if (cmd.out_load || cmd.out_empty) begin
				out_valid_q <= 1'b1;
			end else if (!entry_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.entry_take) begin
			snap_idx_q <= count_q[INDEX_W-1:0];
			snap_id_q  <= id_q;
			snap_len_q <= len_q;
		end
		if (cmd.rd_start || cmd.rd_next) begin
			rd_addr_q <= rd_addr;
		end
		if (cmd.out_load) begin
			out_idx_q   <= snap_idx_q;
			out_id_q    <= snap_id_q;
			out_byte_q  <= rd_data;
			out_empty_q <= 1'b0;
			out_last_q  <= sts.rd_last;
		end else if (cmd.out_empty) begin
			out_idx_q   <= snap_idx_q;
			out_id_q    <= snap_id_q;
			out_byte_q  <= '0;
			out_empty_q <= 1'b1;
			out_last_q  <= 1'b1;
		end
	end

	assign entry_valid   = out_valid_q;
	assign entry_index   = out_idx_q;
	assign entry_id      = out_id_q;
	assign text_byte     = out_byte_q;
	assign text_empty    = out_empty_q;
	assign last_of_entry = out_last_q;

endmodule

// File: hw/rtl/nqslp_ctrl.sv
`timescale 1ns / 1ps

module nqslp_ctrl
	import nqslp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic       end_of_data,
	input  nqslp_sts_t sts,
	output nqslp_cmd_t cmd,
	output logic       byte_stall
);

	localparam logic [1:0] CTL_SCAN  = 2'd0;
	localparam logic [1:0] CTL_FIRST = 2'd1;
	localparam logic [1:0] CTL_EMIT  = 2'd2;

	localparam logic [2:0] PH_SKIP_WS   = 3'd0;
	localparam logic [2:0] PH_DIGITS    = 3'd1;
	localparam logic [2:0] PH_FIND_OPEN = 3'd2;
	localparam logic [2:0] PH_IN_TEXT   = 3'd3;
	localparam logic [2:0] PH_DISCARD   = 3'd4;

	logic [1:0] ctl_q;
	logic [1:0] ctl_d;
	logic [2:0] phase_q;
	logic [2:0] phase_d;
	logic       accept;

	assign byte_stall = (ctl_q != CTL_SCAN);
	assign accept     = byte_valid && (ctl_q == CTL_SCAN);

	always_comb begin
		cmd     = '0;
		ctl_d   = ctl_q;
		phase_d = phase_q;
		unique case (ctl_q)
			CTL_SCAN: begin
				if (accept && !sts.table_full) begin
					unique case (phase_q)
						PH_SKIP_WS: begin
							if (sts.is_space) begin
								phase_d = PH_SKIP_WS;
							end else if (sts.is_digit) begin
								cmd.id_load = 1'b1;
								phase_d     = PH_DIGITS;
							end else begin
								phase_d = PH_DISCARD;
							end
						end
						PH_DIGITS: begin
							if (sts.is_digit) begin
								cmd.id_mac = 1'b1;
							end else if (sts.is_quote) begin
								cmd.len_clear = 1'b1;
								phase_d       = PH_IN_TEXT;
							end else if (sts.is_lf) begin
								phase_d = PH_SKIP_WS;
							end else begin
								phase_d = PH_FIND_OPEN;
							end
						end
						PH_FIND_OPEN: begin
							if (sts.is_quote) begin
								cmd.len_clear = 1'b1;
								phase_d       = PH_IN_TEXT;
							end else if (sts.is_lf) begin
								phase_d = PH_SKIP_WS;
							end
						end
						PH_IN_TEXT: begin
							if (sts.is_quote) begin
								cmd.entry_take = 1'b1;
								phase_d        = PH_DISCARD;
								ctl_d          = CTL_FIRST;
							end else if (sts.is_lf) begin
								phase_d = PH_SKIP_WS;
							end else if (!sts.len_full) begin
								cmd.buf_write = 1'b1;
							end
						end
						default: begin
							if (sts.is_lf) begin
								phase_d = PH_SKIP_WS;
							end else begin
								phase_d = PH_DISCARD;
							end
						end
					endcase
				end
				if (accept && end_of_data) begin
					phase_d         = PH_SKIP_WS;
					cmd.count_clear = 1'b1;
				end
			end
			CTL_FIRST: begin
				if (sts.len_zero) begin
					if (sts.out_free) begin
						cmd.out_empty = 1'b1;
						ctl_d         = CTL_SCAN;
					end
				end else begin
					cmd.rd_start = 1'b1;
					ctl_d        = CTL_EMIT;
				end
			end
			CTL_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.rd_last) begin
						ctl_d = CTL_SCAN;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: begin
				ctl_d = CTL_SCAN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= CTL_SCAN;
			phase_q <= PH_SKIP_WS;
		end else begin
			ctl_q   <= ctl_d;
			phase_q <= phase_d;
		end
	end

endmodule
